@@ hw/rtl/adclz_pkg.sv @@
// Shared types and constants for the ADC LZ decompressor.
package adclz_pkg;

  localparam int LEN_W    = 7;   // pending length / copy length
  localparam int DATA_W   = 32;  // packed result word
  localparam int COUNT_W  = 3;   // valid bytes in a result
  localparam int TOTAL_W  = 25;  // chunk byte count and output limit
  localparam int OFFSET_W = 17;  // back offset, 1 to 65536

  localparam logic [TOTAL_W-1:0] LIMIT_RESET = 25'h100_0000;

  typedef enum logic [1:0] {
    PH_CMD,
    PH_LIT,
    PH_OFS_HI,
    PH_OFS_LO
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_OFFSET,
    ERR_OVERFLOW,
    ERR_TRUNC
  } err_t;

  typedef enum logic {
    ST_IDLE,
    ST_COPY
  } ctl_state_t;

  // Requests from the parser to the history / copy unit.
  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] len;
    logic             lit_we;
    logic [7:0]       lit_data;
    logic             clear;
  } copy_cmd_t;

  // What the copy unit produces in a cycle.
  typedef struct packed {
    logic               byte_wr;
    logic               valid;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic               done;
  } copy_res_t;

endpackage

@@ hw/rtl/adclz_copy_unit.sv @@
// History RAM, back-reference copy pipeline and result packing.
module adclz_copy_unit import adclz_pkg::*; #(
  parameter int HISTORY_DEPTH    = 65536,
  parameter int BYTES_PER_RESULT = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  copy_cmd_t                        cmd,
  input  logic [$clog2(HISTORY_DEPTH):0]   offset,
  input  logic                             res_ready,
  output copy_res_t                        res
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int KW = $clog2(BYTES_PER_RESULT + 1);

  logic [7:0] mem [HISTORY_DEPTH];

  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [LEN_W-1:0]  issue_left;
  logic              s1_valid;
  logic              s1_done;
  logic              s1_fwd;
  logic [7:0]        fwd_byte;
  logic [7:0]        ram_q;
  logic [KW-1:0]     pack_k;
  logic [DATA_W-1:0] pack_data;

  logic [7:0]        s1_byte;
  logic [KW-1:0]     s1_k1;
  logic              s1_full;
  logic              s1_go;
  logic              issue_en;
  logic [DATA_W-1:0] merged;
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic [AW+1:0]     rd_diff;
  logic [AW+1:0]     rd_wrap;
  logic [AW-1:0]     rd_start;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(HISTORY_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // Oldest-first start address: write pointer minus offset, modulo depth.
  assign rd_diff  = {2'b00, wr_ptr} - {1'b0, offset};
  assign rd_wrap  = rd_diff + (AW+2)'(HISTORY_DEPTH);
  assign rd_start = rd_diff[AW+1] ? rd_wrap[AW-1:0] : rd_diff[AW-1:0];

  assign s1_byte  = s1_fwd ? fwd_byte : ram_q;
  assign s1_k1    = pack_k + KW'(1);
  assign s1_full  = (s1_k1 == KW'(BYTES_PER_RESULT)) || s1_done;
  assign s1_go    = s1_valid && (!s1_full || res_ready);
  assign issue_en = (issue_left != '0) && (!s1_valid || s1_go);

  assign mem_we    = s1_go || cmd.lit_we;
  assign mem_wdata = s1_go ? s1_byte : cmd.lit_data;

  always_comb begin
    merged = pack_data;
    for (int i = 0; i < 4; i++) begin
      if (int'(pack_k) == i) begin
        merged[8*i +: 8] = s1_byte;
      end
    end
  end

  assign res.byte_wr = s1_go;
  assign res.valid   = s1_go && s1_full;
  assign res.data    = merged;
  assign res.count   = COUNT_W'(s1_k1);
  assign res.done    = s1_done;

  // Read-old-data RAM; the offset-one hazard is covered by fwd_byte.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr] <= mem_wdata;
    end
    if (issue_en) begin
      ram_q <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      issue_left <= '0;
      s1_valid   <= 1'b0;
      s1_done    <= 1'b0;
      s1_fwd     <= 1'b0;
      pack_k     <= '0;
      pack_data  <= '0;
    end else begin
      if (cmd.clear) begin
        wr_ptr <= '0;
      end else if (mem_we) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end

      if (cmd.start) begin
        rd_ptr     <= rd_start;
        issue_left <= cmd.len;
      end else if (issue_en) begin
        rd_ptr     <= ptr_inc(rd_ptr);
        issue_left <= issue_left - LEN_W'(1);
      end

      if (issue_en) begin
        s1_valid <= 1'b1;
        s1_done  <= (issue_left == LEN_W'(1));
        s1_fwd   <= s1_go && (rd_ptr == wr_ptr);
        fwd_byte <= s1_byte;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      if (s1_go) begin
        if (s1_full) begin
          pack_k    <= '0;
          pack_data <= '0;
        end else begin
          pack_k    <= s1_k1;
          pack_data <= merged;
        end
      end
    end
  end

endmodule

@@ hw/rtl/adc_lz_decompressor.sv @@
// Top level of the ADC LZ decompressor: parser, chunk state and output register.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+-----------------------------------------------
//  input    | in_valid / in_stall   | in_byte, in_last
//  output   | out_valid / out_stall | out_data, out_count, out_last, out_error,
//           |                       | out_total
//  config   | cfg_wr_en             | cfg_wr_data (output_limit)
//
// Command, offset and literal bytes each load a result straight into the output
// register on the cycle the byte is accepted, but for an offset byte that starts a copy.
// A copy of L bytes runs through the history RAM at one byte per cycle while
// the output register is free, packing up to BYTES_PER_RESULT bytes per result;
// in_stall stays high for the whole copy.
// A stalled output holds the block back: input is only taken, and the copy unit only
// hands over a full result, when the output register is free or being emptied.
// Synchronous reset clears control state only; history needs no clearing pass.
module adc_lz_decompressor import adclz_pkg::*; #(
  parameter int HISTORY_DEPTH    = 65536,
  parameter int BYTES_PER_RESULT = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [TOTAL_W-1:0]   cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_W-1:0]    out_data,
  output logic [COUNT_W-1:0]   out_count,
  output logic                 out_last,
  output logic [1:0]           out_error,
  output logic [TOTAL_W-1:0]   out_total
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  ctl_state_t         state, state_next;
  logic [TOTAL_W-1:0] output_limit;
  logic [TOTAL_W-1:0] produced_count, produced_count_next;
  phase_t             phase, phase_next;
  logic [LEN_W-1:0]   pending_length, pending_length_next;
  logic [7:0]         offset_high, offset_high_next;
  err_t               sticky_error, sticky_error_next;
  logic               item_last;

  logic               out_free;
  logic               in_acc;
  logic               copy_start;
  logic               lit_we;
  logic               chunk_end;
  logic               out_load;
  logic [DATA_W-1:0]  out_data_next;
  logic [COUNT_W-1:0] out_count_next;
  logic               out_last_next;
  err_t               out_error_next;
  logic [TOTAL_W-1:0] out_total_next;

  logic [OFFSET_W-1:0] copy_offset;
  logic                offset_bad;
  logic                copy_over;
  copy_cmd_t           cu_cmd;
  copy_res_t           cu_res;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;

  // Offset is stored minus one; check against bytes produced and RAM depth.
  assign copy_offset = {1'b0, offset_high, in_byte} + OFFSET_W'(1);
  assign offset_bad  = ({{(TOTAL_W-OFFSET_W){1'b0}}, copy_offset} > produced_count)
                    || (copy_offset > OFFSET_W'(HISTORY_DEPTH));
  assign copy_over   = ({1'b0, produced_count} + (TOTAL_W+1)'(pending_length))
                     > {1'b0, output_limit};

  always_comb begin
    state_next          = state;
    produced_count_next = produced_count;
    phase_next          = phase;
    pending_length_next = pending_length;
    offset_high_next    = offset_high;
    sticky_error_next   = sticky_error;
    copy_start          = 1'b0;
    lit_we              = 1'b0;
    chunk_end           = 1'b0;
    out_load            = 1'b0;
    out_data_next       = '0;
    out_count_next      = '0;
    out_last_next       = 1'b0;
    out_error_next      = sticky_error;
    out_total_next      = produced_count;

    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          // After an error the rest of the chunk is ignored.
          if (sticky_error == ERR_NONE) begin
            unique case (phase)
              PH_CMD: begin
                if (in_byte[7]) begin
                  pending_length_next = in_byte[6:0];
                  phase_next          = PH_LIT;
                end else if (in_byte[6]) begin
                  pending_length_next = {1'b0, in_byte[5:0]} + LEN_W'(4);
                  phase_next          = PH_OFS_HI;
                end else begin
                  pending_length_next = {3'b000, in_byte[5:2]} + LEN_W'(3);
                  offset_high_next    = {6'b0, in_byte[1:0]};
                  phase_next          = PH_OFS_LO;
                end
              end
              PH_LIT: begin
                if (produced_count >= output_limit) begin
                  sticky_error_next = ERR_OVERFLOW;
                end else begin
                  lit_we              = 1'b1;
                  produced_count_next = produced_count + TOTAL_W'(1);
                  out_data_next       = {24'b0, in_byte};
                  out_count_next      = COUNT_W'(1);
                  if (pending_length == '0) begin
                    phase_next = PH_CMD;
                  end else begin
                    pending_length_next = pending_length - LEN_W'(1);
                  end
                end
              end
              PH_OFS_HI: begin
                offset_high_next = in_byte;
                phase_next       = PH_OFS_LO;
              end
              PH_OFS_LO: begin
                phase_next = PH_CMD;
                if (offset_bad) begin
                  sticky_error_next = ERR_OFFSET;
                end else if (copy_over) begin
                  sticky_error_next = ERR_OVERFLOW;
                end else begin
                  copy_start = 1'b1;
                end
              end
              default: ;
            endcase
          end
          // Chunk ends mid-command.
          if (in_last && (sticky_error_next == ERR_NONE) && (phase_next != PH_CMD)) begin
            sticky_error_next = ERR_TRUNC;
          end
          out_error_next = sticky_error_next;
          out_total_next = produced_count_next;
          out_last_next  = 1'b1;
          if (copy_start) begin
            state_next = ST_COPY;
          end else begin
            out_load  = 1'b1;
            chunk_end = in_last;
          end
        end
      end
      ST_COPY: begin
        if (cu_res.byte_wr) begin
          produced_count_next = produced_count + TOTAL_W'(1);
        end
        if (cu_res.valid) begin
          out_load       = 1'b1;
          out_data_next  = cu_res.data;
          out_count_next = cu_res.count;
          out_last_next  = cu_res.done;
          out_total_next = produced_count + TOTAL_W'(1);
          if (cu_res.done) begin
            state_next = ST_IDLE;
            chunk_end  = item_last;
          end
        end
      end
      default: ;
    endcase

    if (chunk_end) begin
      produced_count_next = '0;
      phase_next          = PH_CMD;
      pending_length_next = '0;
      offset_high_next    = '0;
      sticky_error_next   = ERR_NONE;
    end
  end

  assign cu_cmd.start    = copy_start;
  assign cu_cmd.len      = pending_length;
  assign cu_cmd.lit_we   = lit_we;
  assign cu_cmd.lit_data = in_byte;
  assign cu_cmd.clear    = chunk_end;

  adclz_copy_unit #(
    .HISTORY_DEPTH    (HISTORY_DEPTH),
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_copy (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cu_cmd),
    .offset    (copy_offset[AW:0]),
    .res_ready (out_free),
    .res       (cu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      output_limit   <= LIMIT_RESET;
      produced_count <= '0;
      phase          <= PH_CMD;
      pending_length <= '0;
      offset_high    <= '0;
      sticky_error   <= ERR_NONE;
      item_last      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      produced_count <= produced_count_next;
      phase          <= phase_next;
      pending_length <= pending_length_next;
      offset_high    <= offset_high_next;
      sticky_error   <= sticky_error_next;
      if (cfg_wr_en) begin
        output_limit <= cfg_wr_data;
      end
      if (copy_start) begin
        item_last <= in_last;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload: no reset needed.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data  <= out_data_next;
      out_count <= out_count_next;
      out_last  <= out_last_next;
      out_error <= out_error_next;
      out_total <= out_total_next;
    end
  end

`ifndef SYNTH
  a_copy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    state == ST_COPY |-> in_stall)
    else $error("input taken during a copy");

  a_res_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cu_res.valid |-> (state == ST_COPY) && out_free)
    else $error("copy result with no room in the output register");

  a_copy_chunk_restart: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY) && cu_res.valid && cu_res.done && item_last
      |=> (produced_count == '0) && (sticky_error == ERR_NONE) && (state == ST_IDLE))
    else $error("chunk state not cleared after final copy");

  a_total_counts_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_count != '0) |-> out_total != '0)
    else $error("data result with zero running total");
`endif

endmodule

@@ tb/tb_adc_lz_decompressor.sv @@
// Self-checking testbench for the ADC LZ decompressor top level.
`timescale 1ns / 1ps

module tb_adc_lz_decompressor import adclz_pkg::*; ();

  localparam int HIST_DEPTH     = 65536;
  localparam int BYTES_PER_WORD = 4;
  // Room for a 67-byte copy to finish; round up generously.
  localparam int DRAIN_CYCLES   = 100;

  // One decoded result word as the block should present it.
  typedef struct {
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic               is_last;
    err_t               err;
    logic [TOTAL_W-1:0] total;
  } word_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [TOTAL_W-1:0]   cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_byte;
  logic                 in_last;
  logic                 out_valid;
  logic                 out_stall;
  logic [DATA_W-1:0]    out_data;
  logic [COUNT_W-1:0]   out_count;
  logic                 out_last;
  logic [1:0]           out_error;
  logic [TOTAL_W-1:0]   out_total;

  // Decoder state mirrored by the testbench.
  logic [7:0]         hist_mem [0:HIST_DEPTH-1];
  logic [TOTAL_W-1:0] dec_count;
  phase_t             dec_phase;
  logic [LEN_W-1:0]   dec_len;
  logic [7:0]         dec_ofs_hi;
  err_t               dec_err;
  logic [TOTAL_W-1:0] dec_limit;
  logic [7:0]         step_bytes [$];

  word_t       pending_words [$];  // decoded words still owed by the block
  logic [7:0]  chunk_bytes [$];    // compressed chunk about to be sent
  int          items_sent;
  int          mismatches;
  int          send_idle_pct;
  int          recv_idle_pct;

  adc_lz_decompressor uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .out_count   (out_count),
    .out_last    (out_last),
    .out_error   (out_error),
    .out_total   (out_total)
  );

  always #1 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Hard limit on the run.
  initial begin
    #2_000_000;
    $display("** adc_lz_decompressor: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decoder mirror
  // ---------------------------------------------------------------------------

  function automatic void clear_chunk_state();
    dec_count  = '0;
    dec_phase  = PH_CMD;
    dec_len    = '0;
    dec_ofs_hi = '0;
    dec_err    = ERR_NONE;
  endfunction

  // Every decoded byte lands in the history ring and in this step's word list.
  function automatic void store_byte(logic [7:0] x);
    hist_mem[dec_count[15:0]] = x;
    dec_count = dec_count + TOTAL_W'(1);
    step_bytes.push_back(x);
  endfunction

  // Consume one compressed byte and queue the words it should produce.
  function automatic void decode_byte(logic [7:0] b, logic is_last);
    int unsigned ofs;
    int unsigned src;
    int unsigned total;
    int unsigned pos;
    int unsigned k;
    int unsigned n;
    word_t       w;
    step_bytes.delete();
    // Once an error is latched the rest of the chunk is only acknowledged.
    if (dec_err == ERR_NONE) begin
      case (dec_phase)
        PH_CMD: begin
          if (b[7]) begin
            dec_len   = b[6:0];
            dec_phase = PH_LIT;
          end else if (b[6]) begin
            dec_len   = LEN_W'(b[5:0]) + 7'd4;
            dec_phase = PH_OFS_HI;
          end else begin
            dec_len    = LEN_W'(b[7:2]) + 7'd3;
            dec_ofs_hi = {6'd0, b[1:0]};
            dec_phase  = PH_OFS_LO;
          end
        end
        PH_LIT: begin
          // A literal byte with the limit already reached is dropped.
          if (dec_count >= dec_limit) begin
            dec_err = ERR_OVERFLOW;
          end else begin
            store_byte(b);
            if (dec_len == '0) dec_phase = PH_CMD;
            else dec_len = dec_len - LEN_W'(1);
          end
        end
        PH_OFS_HI: begin
          dec_ofs_hi = b;
          dec_phase  = PH_OFS_LO;
        end
        default: begin
          dec_phase = PH_CMD;
          ofs = 32'({dec_ofs_hi, b}) + 1;
          if (ofs > 32'(dec_count) || ofs > HIST_DEPTH) begin
            dec_err = ERR_OFFSET;
          end else if (32'(dec_count) + 32'(dec_len) > 32'(dec_limit)) begin
            dec_err = ERR_OVERFLOW;
          end else begin
            // Byte by byte, so an overlapping copy repeats what it just wrote.
            for (n = 0; n < dec_len; n++) begin
              src = 32'(dec_count) - ofs;
              store_byte(hist_mem[src[15:0]]);
            end
          end
        end
      endcase
    end
    if (is_last && dec_err == ERR_NONE && dec_phase != PH_CMD) dec_err = ERR_TRUNC;

    // Pack into words; a step with no bytes still gives one status word.
    total = 32'(dec_count) - step_bytes.size();
    pos   = 0;
    do begin
      w.data = '0;
      k      = 0;
      while (k < BYTES_PER_WORD && pos < step_bytes.size()) begin
        w.data = w.data | (DATA_W'(step_bytes[pos]) << (8 * k));
        k++;
        pos++;
      end
      total     = total + k;
      w.count   = COUNT_W'(k);
      w.is_last = (pos >= step_bytes.size());
      w.err     = dec_err;
      w.total   = TOTAL_W'(total);
      pending_words.push_back(w);
    end while (pos < step_bytes.size());

    if (is_last) clear_chunk_state();
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Each accepted output transaction is compared with the oldest owed word.
  always @(posedge clk) begin
    word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, data", out_data, '0);
      end else begin
        want = pending_words.pop_front();
        if (out_data !== want.data)       report_mismatch("data", out_data, want.data);
        if (out_count !== want.count)     report_mismatch("count", out_count, want.count);
        if (out_last !== want.is_last)    report_mismatch("last", out_last, want.is_last);
        if (out_error !== want.err)       report_mismatch("error", out_error, want.err);
        if (out_total !== want.total)     report_mismatch("total", out_total, want.total);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving: called and returning at a falling edge
  // ---------------------------------------------------------------------------

  task automatic send_item(input logic [7:0] b, input logic is_last);
    // Idle cycles drawn one at a time at the sender's idle rate.
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= is_last;
    do @(posedge clk); while (in_stall);
    decode_byte(b, is_last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_chunk();
    int i;
    for (i = 0; i < chunk_bytes.size(); i++)
      send_item(chunk_bytes[i], i == chunk_bytes.size() - 1);
  endtask

  // Hold off the sender until every owed word has come out, then let the
  // pipeline settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_output_limit(input logic [TOTAL_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    dec_limit = value;
  endtask

  // Builds one chunk: mostly well-formed command runs, sometimes noise, a
  // bad offset or a command cut short by the end of the chunk.
  task automatic build_chunk(input bit longest_run);
    int          ncmd;
    int          made;
    int          kind;
    int          n;
    int          code;
    int unsigned ofs;
    logic [15:0] ofs_m1;
    logic [7:0]  tail;
    chunk_bytes.delete();
    made = 0;
    if (!longest_run && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) chunk_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    ncmd = $urandom_range(1, 6);
    repeat (ncmd) begin
      kind = (made == 0 || longest_run) ? 0 : $urandom_range(0, 2);
      case (kind)
        0: begin
          if (longest_run) n = 128;
          else if ($urandom_range(0, 24) == 0) n = $urandom_range(1, 128);
          else n = $urandom_range(1, 6);
          longest_run = 1'b0;
          chunk_bytes.push_back(8'h80 | 8'(n - 1));
          repeat (n) chunk_bytes.push_back(8'($urandom_range(0, 255)));
          made += n;
        end
        1: begin
          code = $urandom_range(0, 15);
          if ($urandom_range(0, 9) == 0) ofs = $urandom_range(1, 1024);
          else ofs = $urandom_range(1, made < 1024 ? made : 1024);
          ofs_m1 = 16'(ofs - 1);
          chunk_bytes.push_back({2'b00, code[3:0], ofs_m1[9:8]});
          chunk_bytes.push_back(ofs_m1[7:0]);
          made += code + 3;
        end
        default: begin
          code = $urandom_range(0, 63);
          if ($urandom_range(0, 9) == 0) ofs = $urandom_range(1, HIST_DEPTH);
          else ofs = $urandom_range(1, made < HIST_DEPTH ? made : HIST_DEPTH);
          ofs_m1 = 16'(ofs - 1);
          chunk_bytes.push_back(8'h40 | 8'(code));
          chunk_bytes.push_back(ofs_m1[15:8]);
          chunk_bytes.push_back(ofs_m1[7:0]);
          made += code + 4;
        end
      endcase
    end
    // Now and then leave a command unfinished at the end of the chunk.
    if ($urandom_range(0, 7) == 0) begin
      tail = 8'($urandom_range(0, 255));
      chunk_bytes.push_back(tail);
      if (tail[7])
        repeat ($urandom_range(0, tail[6:0] < 4 ? tail[6:0] : 4))
          chunk_bytes.push_back(8'($urandom_range(0, 255)));
      else if (tail[6] && $urandom_range(0, 1) == 1)
        chunk_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Literal run with both extreme data values.
  task automatic test_literal_run();
    chunk_bytes = '{8'h82, 8'h00, 8'hFF, 8'h5A};
    send_chunk();
  endtask

  // Short copies, the first overlapping its own output, the second the
  // longest short form at offset one.
  task automatic test_short_copies();
    chunk_bytes = '{8'h81, 8'h11, 8'h22, 8'h00, 8'h01, 8'h3C, 8'h00};
    send_chunk();
  endtask

  // Longest long-form copy: 67 bytes, seventeen words from one item.
  task automatic test_long_copy();
    chunk_bytes = '{8'h80, 8'h7E, 8'h7F, 8'h00, 8'h00};
    send_chunk();
  endtask

  // Offset past the start of the chunk; the trailing command is ignored.
  task automatic test_bad_offset();
    chunk_bytes = '{8'h00, 8'h00, 8'h80};
    send_chunk();
  endtask

  // Chunk ends in the middle of a long copy's offset.
  task automatic test_truncation();
    chunk_bytes = '{8'h40, 8'h12};
    send_chunk();
  endtask

  // Overflow by a literal at a limit of one, then by a copy.
  task automatic test_overflow();
    drain_results();
    set_output_limit(25'd1);
    chunk_bytes = '{8'h81, 8'h01, 8'h02};
    send_chunk();
    drain_results();
    set_output_limit(25'd2);
    chunk_bytes = '{8'h81, 8'h01, 8'h02, 8'h00, 8'h00};
    send_chunk();
    drain_results();
    set_output_limit(LIMIT_RESET);
  endtask

  task automatic test_random_traffic(input int sidle, input int ridle,
                                     input logic [TOTAL_W-1:0] limit,
                                     input int n_items, input bit longest_run);
    int  stop_at;
    bit  paused;
    drain_results();
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    set_output_limit(limit);
    stop_at = items_sent + n_items;
    paused  = 1'b0;
    while (items_sent < stop_at) begin
      build_chunk(longest_run);
      longest_run = 1'b0;
      send_chunk();
      // Midway, let the block run completely dry before carrying on.
      if (!paused && items_sent >= stop_at - n_items / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    in_byte       = '0;
    in_last       = 1'b0;
    items_sent    = 0;
    mismatches    = 0;
    send_idle_pct = 21;
    recv_idle_pct = 62;
    dec_limit     = LIMIT_RESET;
    clear_chunk_state();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_literal_run();
    test_short_copies();
    test_long_copy();
    test_bad_offset();
    test_truncation();
    test_overflow();
    test_random_traffic(21, 62, 25'($urandom_range(200, 5000)), 30, 1'b0);
    test_random_traffic(62, 21, 25'd40, 30, 1'b0);
    test_random_traffic(0, 0, LIMIT_RESET, 20, 1'b1);

    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("** adc_lz_decompressor: PASSED **");
    end else begin
      $display("** adc_lz_decompressor: FAILED **");
    end
    $finish;
  end

  // Anything still owed once the block has gone quiet is a missing word.
  always @(negedge clk) begin
    if (!rst && in_valid === 1'b0 && pending_words.size() != 0 && $realtime > 1_999_000)
      report_mismatch("words never produced", pending_words.size(), 0);
  end

endmodule
